>>> rtl/ffcu_pkg.sv
// Shared types, constants and helper functions for the free-fly camera update block.
// No dependencies; imported by free_fly_camera_update, ffcu_mul and ffcu_cordic.
`default_nettype none

package ffcu_pkg;

  localparam int TURN        = 92160;
  localparam int HALF        = 46080;
  localparam int QUARTER     = 23040;
  localparam int PITCH_LIM   = 22784;
  localparam int COR_STEPS   = 20;
  localparam int COR_GAIN    = 652032874;
  localparam int WRAP_TOP    = 9;         // highest shift of the restoring wrap
  localparam int ZC_HI       = 46603;     // floor(2^21/45)
  localparam int ZC_LO       = 12676135;  // 17 * ceil(2^25/45)

  localparam logic [15:0]        SPEED_RST = 16'd640;
  localparam logic [15:0]        SENS_RST  = 16'd6554;
  localparam logic signed [31:0] POS_Z_RST = 32'sd196608;
  localparam logic signed [16:0] YAW_RST   = -17'sd23040;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

  typedef enum logic {
    REG_MOVE_SPEED,
    REG_LOOK_SENS
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_POS,
    ST_WRAP_PRE,
    ST_WRAP,
    ST_COR_GO,
    ST_COR_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    MOP_VEL,
    MOP_FX,
    MOP_FY,
    MOP_FZ,
    MOP_RX,
    MOP_RZ,
    MOP_UPV,
    MOP_DYAW,
    MOP_DPITCH,
    MOP_ZY1,
    MOP_ZY2,
    MOP_ZP1,
    MOP_ZP2,
    MOP_CYCP,
    MOP_SYCP,
    MOP_CYSP,
    MOP_SYSP
  } mop_t;

  typedef logic signed [32:0] mop_arg_t;
  typedef logic signed [65:0] mprod_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] z;      // angle, full turn = 2^32
  } cor_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [31:0] cos;    // Q2.30
    logic signed [31:0] sin;
  } cor_rsp_t;

  // atan(2^-i), full turn = 2^32
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41721;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.14, round half up, clamp to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) begin
      return ONE_Q14;
    end else if (r < -34'sd16384) begin
      return -ONE_Q14;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/ffcu_if.sv
// Valid/ready channel interfaces for camera input items and camera results.
// No dependencies.
`default_nettype none

interface ffcu_in_if;
  logic               valid;
  logic               ready;
  logic               key_forward;
  logic               key_back;
  logic               key_strafe_left;
  logic               key_strafe_right;
  logic               key_rise;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic [15:0]        frame_time;

  modport source(output valid, key_forward, key_back, key_strafe_left, key_strafe_right,
                 key_rise, mouse_x, mouse_y, frame_time, input ready);
  modport sink(input valid, key_forward, key_back, key_strafe_left, key_strafe_right,
               key_rise, mouse_x, mouse_y, frame_time, output ready);
endinterface

interface ffcu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [16:0] yaw_angle;
  logic signed [15:0] pitch_angle;

  modport source(output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                 up_x, up_y, up_z, yaw_angle, pitch_angle, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
               up_x, up_y, up_z, yaw_angle, pitch_angle, output ready);
endinterface

`default_nettype wire

>>> rtl/free_fly_camera_update.sv
// Free-fly camera update: top level with sequencer and datapath.
// Depends on ffcu_pkg, ffcu_if, ffcu_mul, ffcu_cordic.
//
// Usage:
//   req carries one frame: five movement keys, mouse position, frame time.
//   rsp carries one result per frame: position, front, up, yaw and pitch.
//   cfg_we/cfg_index/cfg_data write move_speed (index 0) or look_sensitivity
//   (index 1); write only while the block is idle.
// Sequencing:
//   One transaction at a time. Between acceptance and result a normal frame
//   makes 17 passes through the shared multiplier (ST_MUL_A, then ST_MUL_B),
//   a 10-step restoring yaw wrap, and two 20-step CORDIC runs (yaw, pitch).
//   The first frame after reset moves the position but only latches the mouse.
//   req.ready is high only in idle.
// Reset (rst, synchronous): position (0,0,3), front (0,0,-1), up (0,1,0),
//   yaw -90 deg, pitch 0, first-sample flag set, registers to 2.5 and 0.1.
// Stall: the result sits in an output register; the next transaction is
//   accepted meanwhile and its result waits until rsp.ready frees the
//   register.
`default_nettype none

module free_fly_camera_update (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_data,
  ffcu_in_if.sink    req,
  ffcu_out_if.source rsp
);
  import ffcu_pkg::*;

  state_t state, state_next;
  mop_t   op;

  // registers and architectural state
  logic [15:0]        speed, sens;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] fr_x, fr_y, fr_z, rt_x, rt_z, up_x, up_y, up_z;
  logic signed [16:0] yaw_st;
  logic signed [15:0] pitch_st;
  logic signed [15:0] last_x, last_y;
  logic               first;

  // captured item
  logic               k_fwd, k_back, k_left, k_right, k_rise;
  logic signed [15:0] mx, my;
  logic [15:0]        ft;

  // work registers
  logic [31:0]        vel;
  logic signed [26:0] dx, dy, dz, dyaw, dpitch;
  logic [26:0]        wt;
  logic [3:0]         wk;
  logic [30:0]        zq1;
  logic signed [31:0] zy, zp, cy, sy;
  logic               cphase;

  // output register
  logic               o_valid;
  logic               o_load;

  // shared units
  mop_arg_t mul_a, mul_b;
  mprod_t   mp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  ffcu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mp));
  ffcu_cordic u_cordic (.clk(clk), .rst(rst), .req(cor_req), .rsp(cor_rsp));

  function automatic logic signed [26:0] steer(input logic signed [26:0] t,
                                               input logic signed [1:0] d);
    logic signed [26:0] r;
    case (d)
      2'sd1:   r = t;
      -2'sd1:  r = -t;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    if (s > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -33'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

  // key directions
  logic signed [1:0] fwd, strafe;
  assign fwd    = $signed({1'b0, k_fwd}) - $signed({1'b0, k_back});
  assign strafe = $signed({1'b0, k_right}) - $signed({1'b0, k_left});

  // mouse deltas
  logic signed [16:0] dmx, dmy;
  assign dmx = 17'(mx) - 17'(last_x);
  assign dmy = 17'(last_y) - 17'(my);

  // yaw folded into [-90,90] deg, magnitudes for turn conversion
  logic signed [17:0] yaw_f;
  logic               neg_y;
  logic [14:0]        m_y, m_p;
  always_comb begin
    if (yaw_st > 17'sd23040) begin
      yaw_f = 18'(yaw_st) - 18'sd46080;
      neg_y = 1'b1;
    end else if (yaw_st < -17'sd23040) begin
      yaw_f = 18'(yaw_st) + 18'sd46080;
      neg_y = 1'b1;
    end else begin
      yaw_f = 18'(yaw_st);
      neg_y = 1'b0;
    end
    m_y = (yaw_f < 0) ? 15'(-yaw_f) : yaw_f[14:0];
    m_p = (pitch_st < 0) ? 15'(-17'(pitch_st)) : pitch_st[14:0];
  end

  // rounded product views
  mprod_t rnd22, rnd8, rnd30;
  assign rnd22 = (mp + 66'sd2097152) >>> 22;
  assign rnd8  = (mp + 66'sd128) >>> 8;
  assign rnd30 = (mp + 66'sd536870912) >>> 30;

  logic signed [26:0] t22;
  logic signed [33:0] r30;
  assign t22 = rnd22[26:0];
  assign r30 = rnd30[33:0];

  // turn conversion: q = floor(m * 2^21 / 45)
  logic [30:0]        zq;
  logic signed [31:0] zqs;
  assign zq  = zq1 + mp[55:25];
  assign zqs = $signed({1'b0, zq});

  // yaw wrap pieces
  logic signed [27:0] tw;
  logic signed [27:0] tp;
  logic [26:0]        wsub, wt_new;
  logic signed [17:0] yaw_w;
  assign tw     = 28'(yaw_st) + 28'(dyaw) + 28'sd46080;
  assign tp     = 28'(pitch_st) + 28'(dpitch);
  assign wsub   = 27'(TURN) << wk;
  assign wt_new = (wt >= wsub) ? wt - wsub : wt;
  assign yaw_w  = $signed({1'b0, wt_new[16:0]}) - 18'sd46080;

  // position sums
  logic signed [32:0] sum_x, sum_y, sum_z;
  assign sum_x = 33'(pos_x) + 33'(dx);
  assign sum_y = 33'(pos_y) + 33'(dy);
  assign sum_z = 33'(pos_z) + 33'(dz);

  // CORDIC results with quadrant fold applied
  logic signed [31:0] cor_c, cor_s;
  assign cor_c = (!cphase && neg_y) ? -cor_rsp.cos : cor_rsp.cos;
  assign cor_s = (!cphase && neg_y) ? -cor_rsp.sin : cor_rsp.sin;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (req.valid) state_next = ST_MUL_A;
      ST_MUL_A:    state_next = ST_MUL_B;
      ST_MUL_B: begin
        case (op)
          MOP_UPV:    state_next = ST_POS;
          MOP_DPITCH: state_next = ST_WRAP_PRE;
          MOP_ZP2:    state_next = ST_COR_GO;
          MOP_SYSP:   state_next = ST_OUT;
          default:    state_next = ST_MUL_A;
        endcase
      end
      ST_POS:      state_next = first ? ST_OUT : ST_MUL_A;
      ST_WRAP_PRE: state_next = ST_WRAP;
      ST_WRAP:     if (wk == 4'd0) state_next = ST_MUL_A;
      ST_COR_GO:   state_next = ST_COR_WAIT;
      ST_COR_WAIT: if (cor_rsp.done) state_next = cphase ? ST_MUL_A : ST_COR_GO;
      ST_OUT:      if (!o_valid || rsp.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, CORDIC start
  always_comb begin
    req.ready     = (state == ST_IDLE);
    cor_req.start = (state == ST_COR_GO);
    cor_req.z     = cphase ? zp : zy;
    o_load        = (state == ST_OUT) && (!o_valid || rsp.ready);
    mul_a         = '0;
    mul_b         = '0;
    if (state == ST_MUL_A) begin
      case (op)
        MOP_VEL:    begin mul_a = $signed({17'b0, speed}); mul_b = $signed({17'b0, ft});  end
        MOP_FX:     begin mul_a = 33'(fr_x);    mul_b = $signed({1'b0, vel}); end
        MOP_FY:     begin mul_a = 33'(fr_y);    mul_b = $signed({1'b0, vel}); end
        MOP_FZ:     begin mul_a = 33'(fr_z);    mul_b = $signed({1'b0, vel}); end
        MOP_RX:     begin mul_a = 33'(rt_x);    mul_b = $signed({1'b0, vel}); end
        MOP_RZ:     begin mul_a = 33'(rt_z);    mul_b = $signed({1'b0, vel}); end
        MOP_UPV:    begin mul_a = 33'(ONE_Q14); mul_b = $signed({1'b0, vel}); end
        MOP_DYAW:   begin mul_a = 33'(dmx);     mul_b = $signed({17'b0, sens}); end
        MOP_DPITCH: begin mul_a = 33'(dmy);     mul_b = $signed({17'b0, sens}); end
        MOP_ZY1:    begin mul_a = $signed({18'b0, m_y}); mul_b = 33'sd46603;    end
        MOP_ZY2:    begin mul_a = $signed({18'b0, m_y}); mul_b = 33'sd12676135; end
        MOP_ZP1:    begin mul_a = $signed({18'b0, m_p}); mul_b = 33'sd46603;    end
        MOP_ZP2:    begin mul_a = $signed({18'b0, m_p}); mul_b = 33'sd12676135; end
        MOP_CYCP:   begin mul_a = 33'(cy); mul_b = 33'(cor_c); end
        MOP_SYCP:   begin mul_a = 33'(sy); mul_b = 33'(cor_c); end
        MOP_CYSP:   begin mul_a = 33'(cy); mul_b = 33'(cor_s); end
        MOP_SYSP:   begin mul_a = 33'(sy); mul_b = 33'(cor_s); end
        default:    begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // cp/sp stay readable from the CORDIC output registers during the vector ops
  // (cphase = 1 so no fold is applied there).

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      speed    <= SPEED_RST;
      sens     <= SENS_RST;
      pos_x    <= '0;
      pos_y    <= '0;
      pos_z    <= POS_Z_RST;
      fr_x     <= '0;
      fr_y     <= '0;
      fr_z     <= -ONE_Q14;
      rt_x     <= ONE_Q14;
      rt_z     <= '0;
      up_x     <= '0;
      up_y     <= ONE_Q14;
      up_z     <= '0;
      yaw_st   <= YAW_RST;
      pitch_st <= '0;
      last_x   <= '0;
      last_y   <= '0;
      first    <= 1'b1;
      o_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MOVE_SPEED: speed <= cfg_data;
          REG_LOOK_SENS:  sens  <= cfg_data;
          default:        ;
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_POS: begin
          pos_x <= sat32(sum_x);
          pos_y <= sat32(sum_y);
          pos_z <= sat32(sum_z);
          if (first) begin
            first  <= 1'b0;
            last_x <= mx;
            last_y <= my;
          end
        end
        ST_WRAP_PRE: begin
          last_x <= mx;
          last_y <= my;
          if (tp > 28'sd22784) begin
            pitch_st <= 16'sd22784;
          end else if (tp < -28'sd22784) begin
            pitch_st <= -16'sd22784;
          end else begin
            pitch_st <= tp[15:0];
          end
        end
        ST_WRAP: begin
          if (wk == 4'd0) yaw_st <= yaw_w[16:0];
        end
        ST_COR_WAIT: begin
          if (cor_rsp.done && cphase) begin
            fr_y <= to_q14(34'(cor_rsp.sin));
            up_y <= to_q14(34'(cor_rsp.cos));
            rt_x <= to_q14(-34'(sy));
            rt_z <= to_q14(34'(cy));
          end
        end
        ST_MUL_B: begin
          case (op)
            MOP_CYCP: fr_x <= to_q14(r30);
            MOP_SYCP: fr_z <= to_q14(r30);
            MOP_CYSP: up_x <= to_q14(-r30);
            MOP_SYSP: up_z <= to_q14(-r30);
            default:  ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // item capture, work registers, result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          k_fwd   <= req.key_forward;
          k_back  <= req.key_back;
          k_left  <= req.key_strafe_left;
          k_right <= req.key_strafe_right;
          k_rise  <= req.key_rise;
          mx      <= req.mouse_x;
          my      <= req.mouse_y;
          ft      <= req.frame_time;
          dx      <= '0;
          dy      <= '0;
          dz      <= '0;
          op      <= MOP_VEL;
          cphase  <= 1'b0;
        end
      end
      ST_MUL_B: begin
        if (op != MOP_SYSP) op <= mop_t'(op + 5'd1);
        case (op)
          MOP_VEL:    vel    <= mp[31:0];
          MOP_FX:     dx     <= dx + steer(t22, fwd);
          MOP_FY:     dy     <= dy + steer(t22, fwd);
          MOP_FZ:     dz     <= dz + steer(t22, fwd);
          MOP_RX:     dx     <= dx + steer(t22, strafe);
          MOP_RZ:     dz     <= dz + steer(t22, strafe);
          MOP_UPV:    dy     <= dy + steer(t22, {1'b0, k_rise});
          MOP_DYAW:   dyaw   <= rnd8[26:0];
          MOP_DPITCH: dpitch <= rnd8[26:0];
          MOP_ZY1:    zq1    <= mp[30:0];
          MOP_ZY2:    zy     <= (yaw_f < 0) ? -zqs : zqs;
          MOP_ZP1:    zq1    <= mp[30:0];
          MOP_ZP2:    zp     <= (pitch_st < 0) ? -zqs : zqs;
          default:    ;
        endcase
      end
      ST_WRAP_PRE: begin
        wk <= 4'(WRAP_TOP);
        if (tw < 0) begin
          wt <= 27'(tw + 28'sd47185920);
        end else begin
          wt <= tw[26:0];
        end
      end
      ST_WRAP: begin
        wt <= wt_new;
        if (wk != 4'd0) wk <= wk - 4'd1;
      end
      ST_COR_WAIT: begin
        if (cor_rsp.done && !cphase) begin
          cy     <= cor_c;
          sy     <= cor_s;
          cphase <= 1'b1;
        end
      end
      default: ;
    endcase

    if (o_load) begin
      rsp.pos_x       <= pos_x;
      rsp.pos_y       <= pos_y;
      rsp.pos_z       <= pos_z;
      rsp.front_x     <= fr_x;
      rsp.front_y     <= fr_y;
      rsp.front_z     <= fr_z;
      rsp.up_x        <= up_x;
      rsp.up_y        <= up_y;
      rsp.up_z        <= up_z;
      rsp.yaw_angle   <= yaw_st;
      rsp.pitch_angle <= pitch_st;
    end
  end

  assign rsp.valid = o_valid;

`ifndef ASSERT_OFF
  // busy for the whole transaction once accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("accepted a second transaction while working");

  // CORDIC is only restarted when idle
  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cor_req.start |-> !cor_rsp.busy)
    else $error("CORDIC started while busy");

  // yaw is wrapped before the turn conversion reads it
  a_yaw_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_A && op == MOP_ZY1) |-> (yaw_st >= -17'sd46080 && yaw_st <= 17'sd46079))
    else $error("yaw out of range after wrap");
`endif

endmodule

`default_nettype wire

>>> rtl/ffcu_mul.sv
// Shared signed 33x33 multiplier with registered product.
// Depends on ffcu_pkg.
`default_nettype none

module ffcu_mul (
  input  wire              clk,
  input  ffcu_pkg::mop_arg_t a,
  input  ffcu_pkg::mop_arg_t b,
  output ffcu_pkg::mprod_t   p
);
  import ffcu_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

>>> rtl/ffcu_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q2.30 cos/sin out.
// Depends on ffcu_pkg (atan table, gain, request/response structs).
`default_nettype none

module ffcu_cordic (
  input  wire                clk,
  input  wire                rst,
  input  ffcu_pkg::cor_req_t req,
  output ffcu_pkg::cor_rsp_t rsp
);
  import ffcu_pkg::*;

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [33:0] z;
  logic [4:0]         i;
  logic               busy;
  logic               done;

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [33:0] at;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = $signed({4'b0, atan_lut(i)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && i == 5'(COR_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= 33'sd652032874;
      y <= '0;
      z <= 34'(req.z);
      i <= '0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      i <= i + 5'd1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.cos  = x[31:0];
  assign rsp.sin  = y[31:0];

endmodule

`default_nettype wire
